/* rtl/core/rao_pkg.sv */
// Shared types, constants and helper functions for the rainbow arc overlay.
package rao_pkg;

  // canvas limits
  localparam int MAX_WIDTH = 128;
  localparam int MAX_ROWS  = 64;

  // arc geometry
  localparam int NUM_BANDS = 7;
  localparam int BAND_R0   = 26;
  localparam int BAND_STEP = 3;

  // fade schedule in frames
  localparam int FADE_IN      = 15;
  localparam int HOLD_END     = 60;
  localparam int TOTAL_FRAMES = 75;
  localparam int FADE_LEVELS  = 16;

  // color channels
  localparam int NUM_CHAN  = 3;
  localparam int CH_RED    = 0;
  localparam int CH_GREEN  = 1;
  localparam int CH_BLUE   = 2;

  // item function codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_PANEL_WIDTH   = 2'd0;
  localparam logic [1:0] REG_WINDOW_TOP    = 2'd1;
  localparam logic [1:0] REG_WINDOW_BOTTOM = 2'd2;

  typedef struct packed {
    logic       func;
    logic [6:0] col;
    logic [5:0] row;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       finished;
  } out_t;

  // fade numerator (0..15) for a frame count
  function automatic logic [3:0] fade_num(logic [6:0] f);
    logic [3:0] n;
    if (f < 7'(FADE_IN)) begin
      n = f[3:0];
    end else if (f < 7'(HOLD_END)) begin
      n = 4'(FADE_IN);
    end else if (f >= 7'(TOTAL_FRAMES)) begin
      n = 4'd0;
    end else begin
      n = 4'(7'(TOTAL_FRAMES) - f);
    end
    return n;
  endfunction

  // full-brightness color of a band, one channel
  function automatic int band_chan(int b, int ch);
    logic [23:0] rgb;
    case (b)
      0: rgb = 24'hFF0000;
      1: rgb = 24'hFFA500;
      2: rgb = 24'hFFFF00;
      3: rgb = 24'h00C800;
      4: rgb = 24'h0000FF;
      5: rgb = 24'h4B0082;
      6: rgb = 24'h9400D3;
      default: rgb = 24'h000000;
    endcase
    return int'(rgb[8*(2-ch) +: 8]);
  endfunction

endpackage

/* rtl/core/rao_pixel.sv */
// Per-pixel arc band test and faded color lookup.
module rao_pixel (
  input  rao_pkg::in_t  pix,
  input  logic [7:0]    panel_width,
  input  logic [5:0]    window_top,
  input  logic [5:0]    window_bottom,
  input  logic [3:0]    fade,
  input  logic          finished,
  output rao_pkg::out_t result
);

  logic signed [8:0] d;
  logic [8:0]        ad;
  logic              near;
  logic              in_win;
  logic [6:0]        k;
  logic [7:0]        a;
  logic [15:0]       a_sq;
  logic [11:0]       d_sq;
  logic [14:0]       lo;
  logic [14:0]       hi;
  logic [rao_pkg::NUM_BANDS-1:0] band_hit;
  logic [7:0] fade_lut [rao_pkg::NUM_BANDS][rao_pkg::NUM_CHAN][rao_pkg::FADE_LEVELS];

  // horizontal offset from the centre in half pixels
  assign d    = $signed({1'b0, pix.col, 1'b0}) - $signed({1'b0, panel_width});
  assign ad   = d[8] ? 9'(-d) : 9'(d);
  assign near = (ad <= 9'(2 * rao_pkg::BAND_R0));

  assign in_win = (pix.func == rao_pkg::FUNC_PIXEL) && (fade != 4'd0) &&
                  ({1'b0, pix.col} < panel_width) &&
                  ({2'b00, pix.col} < 9'(rao_pkg::MAX_WIDTH)) &&
                  ({3'b000, pix.row} < 9'(rao_pkg::MAX_ROWS)) &&
                  (pix.row >= window_top) && (pix.row <= window_bottom);

  // k = rows above the arc base; pixel lies on band if round(sqrt(S)/2) is k or k+1,
  // i.e. (2k-1)^2 + d^2 <= 4r^2 < (2k+3)^2 + d^2
  assign k    = {1'b0, window_bottom} + 7'd1 - {1'b0, pix.row};
  assign a    = {k, 1'b0} - 8'd1;
  assign a_sq = 16'(a) * 16'(a);
  assign d_sq = 12'(ad[5:0]) * 12'(ad[5:0]);
  assign lo   = 15'(a_sq) + 15'(d_sq);
  assign hi   = lo + 15'({a, 3'b000}) + 15'd16;

  always_comb begin
    for (int b = 0; b < rao_pkg::NUM_BANDS; b++) begin
      band_hit[b] = in_win && near &&
        (lo <= 15'(4 * (rao_pkg::BAND_R0 - rao_pkg::BAND_STEP * b) *
                   (rao_pkg::BAND_R0 - rao_pkg::BAND_STEP * b))) &&
        (15'(4 * (rao_pkg::BAND_R0 - rao_pkg::BAND_STEP * b) *
             (rao_pkg::BAND_R0 - rao_pkg::BAND_STEP * b)) < hi);
    end
  end

  // faded palette, all constants: trunc(c*n/15)
  always_comb begin
    for (int b = 0; b < rao_pkg::NUM_BANDS; b++) begin
      for (int ch = 0; ch < rao_pkg::NUM_CHAN; ch++) begin
        for (int n = 0; n < rao_pkg::FADE_LEVELS; n++) begin
          fade_lut[b][ch][n] = 8'((rao_pkg::band_chan(b, ch) * n) / rao_pkg::FADE_IN);
        end
      end
    end
  end

  // higher bands override lower ones
  always_comb begin
    result.hit      = 1'b0;
    result.red      = 8'd0;
    result.green    = 8'd0;
    result.blue     = 8'd0;
    result.finished = finished;
    for (int b = 0; b < rao_pkg::NUM_BANDS; b++) begin
      if (band_hit[b]) begin
        result.hit   = 1'b1;
        result.red   = fade_lut[b][rao_pkg::CH_RED][fade];
        result.green = fade_lut[b][rao_pkg::CH_GREEN][fade];
        result.blue  = fade_lut[b][rao_pkg::CH_BLUE][fade];
      end
    end
  end

endmodule

/* rtl/core/rainbow_arc_overlay_pixel.sv */
// Top level: rainbow arc overlay, one result beat per input beat.
// An accepted beat goes to the input stage, its result to the output register.
// Throughput: one beat per cycle while out_stall is low; an input stage and an
// output register let one more beat be taken while a result is stalled.
// Reset (rst, synchronous, active high) empties both stages, clears the
// frame counter and loads width 64, window top 0, window bottom 31.
module rainbow_arc_overlay_pixel (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rao_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rao_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data
);

  logic          stage_valid;
  rao_pkg::in_t  stage;
  logic [7:0]    panel_width;
  logic [5:0]    window_top;
  logic [5:0]    window_bottom;
  logic [6:0]    frame_count;
  logic [6:0]    frame_count_next;
  logic [3:0]    fade;
  logic          accept;
  logic          advance;
  rao_pkg::out_t result;

  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    frame_count_next = frame_count;
    if (advance && stage.func == rao_pkg::FUNC_TICK &&
        frame_count < 7'(rao_pkg::TOTAL_FRAMES)) begin
      frame_count_next = frame_count + 7'd1;
    end
  end

  rao_pixel u_pixel (
    .pix          (stage),
    .panel_width  (panel_width),
    .window_top   (window_top),
    .window_bottom(window_bottom),
    .fade         (fade),
    .finished     (frame_count_next >= 7'(rao_pkg::TOTAL_FRAMES)),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid   <= 1'b0;
      out_valid     <= 1'b0;
      frame_count   <= 7'd0;
      fade          <= 4'd0;
      panel_width   <= 8'd64;
      window_top    <= 6'd0;
      window_bottom <= 6'd31;
    end else begin
      stage_valid <= accept || (stage_valid && !advance);
      out_valid   <= advance || (out_valid && out_stall);
      frame_count <= frame_count_next;
      fade        <= rao_pkg::fade_num(frame_count_next);
      if (cfg_we) begin
        case (cfg_index)
          rao_pkg::REG_PANEL_WIDTH:   panel_width   <= cfg_data;
          rao_pkg::REG_WINDOW_TOP:    window_top    <= cfg_data[5:0];
          rao_pkg::REG_WINDOW_BOTTOM: window_bottom <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

endmodule
